/* hdl/segment_pair_intersection_assert.svh */
// assertion macros for the segment pair intersection block
// expects i_clk and i_rst_n in the module that uses them
`ifndef SEGMENT_PAIR_INTERSECTION_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_ASSERT_SVH

// same-cycle implication
`define SPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spi assertion failed");

// next-cycle implication
`define SPI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spi assertion failed");

`endif

/* hdl/spi_pkg.sv */
// shared types and constants for the segment pair intersection block
// command and status structs between controller and datapath; no dependencies
`default_nettype none

package spi_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int MAG_W     = 64;
    localparam int QUOT_W    = 62;
    localparam int DIV_STEPS = MAG_W + 32;
    localparam int WIDE_LAST = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAR_TOL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_TOL = CFG_IDX_W'(1);

    localparam logic [31:0] PAR_TOL_RST = 32'd42950;
    localparam logic [31:0] HIT_TOL_RST = 32'd429;

    localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

    typedef enum logic [3:0] {
        PR_N1, PR_N2, PR_NG, PR_CM1, PR_CM2,
        PR_DET, PR_NUM0, PR_NUM1, PR_DOTG, PR_DOTS
    } t_pair;

    typedef enum logic [1:0] {WD_CMSQ, WD_TSQ, WD_TN, WD_FULL} t_wide;

    typedef enum logic [1:0] {CO_U0, CO_U1, CO_Q0, CO_COL} t_coord;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_LINE     = 3'd1,
        KIND_SEG      = 3'd2,
        KIND_PAR_LINE = 3'd3,
        KIND_PAR_SEG  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PLACE_BEGIN   = 2'd0,
        PLACE_INSIDE  = 2'd1,
        PLACE_END     = 2'd2,
        PLACE_OUTSIDE = 2'd3
    } t_place;

    typedef struct packed {
        logic   pair_go;
        t_pair  pair_id;
        logic   wide_go;
        t_wide  wide_id;
        logic   div_go;
        logic   div_by_det;
        t_coord coord_op;
        logic   emit;
        t_kind  kind;
    } t_cmd;

    typedef struct packed {
        logic pair_done;
        logic wide_done;
        logic div_done;
        logic n1_zero;
        logic det_zero;
        logic tilt_ge;
        logic tilt_le;
        logic rng0;
        logic rng1;
        logic span;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* hdl/spi_div.sv */
// serial restoring divider: floor(dividend * 2^32 / divisor), capped
// one quotient bit per cycle; uses spi_pkg
`default_nettype none

module spi_div import spi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [MAG_W-1:0]    i_dividend,
    input  logic [MAG_W-1:0]    i_divisor,
    output logic                o_done,
    output logic [QUOT_W-1:0]   o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [6:0]            r_cnt;
    logic [DIV_STEPS-1:0]  r_dd;
    logic [MAG_W-1:0]      r_rem;
    logic [MAG_W-1:0]      r_dvs;
    logic [QUOT_W-1:0]     r_q;
    logic                  r_ovf;

    logic [MAG_W-1:0]      rem_sh;
    logic                  ge;
    logic [QUOT_W:0]       q_sh;

    // remainder stays below the divisor, so its top bit is always clear
    assign rem_sh = {r_rem[MAG_W-2:0], r_dd[DIV_STEPS-1]};
    assign ge     = rem_sh >= r_dvs;
    assign q_sh   = {r_q, ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_dd  <= {i_dividend, 32'd0};
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dd  <= {r_dd[DIV_STEPS-2:0], 1'b0};
            r_rem <= ge ? rem_sh - r_dvs : rem_sh;
            r_q   <= q_sh[QUOT_W-1:0];
            r_ovf <= r_ovf | q_sh[QUOT_W];
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_ovf || r_q > QUOT_CAP) ? QUOT_CAP : r_q;

endmodule

`default_nettype wire

/* hdl/spi_dp.sv */
// datapath: input and config registers, shared multiplier, pair and wide product units,
// divider, held coordinates, classification and output register; uses spi_pkg, spi_div
`default_nettype none

module spi_dp import spi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic signed [31:0]    i_first_dir_x,
    input  logic signed [31:0]    i_first_dir_y,
    input  logic signed [31:0]    i_second_dir_x,
    input  logic signed [31:0]    i_second_dir_y,
    input  logic signed [31:0]    i_start_gap_x,
    input  logic signed [31:0]    i_start_gap_y,
    input  logic signed [31:0]    i_sys_a00,
    input  logic signed [31:0]    i_sys_a01,
    input  logic signed [31:0]    i_sys_a10,
    input  logic signed [31:0]    i_sys_a11,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_hit_kind,
    output logic [1:0]            o_first_place,
    output logic [1:0]            o_second_place,
    output logic signed [47:0]    o_first_coord,
    output logic signed [47:0]    o_second_coord
);

    localparam logic signed [49:0] ONE50   = 50'sd4294967296;
    localparam logic [47:0]        ONE48   = 48'h0001_0000_0000;
    localparam logic signed [63:0] C48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] C48_MIN = -64'sh0000_8000_0000_0000;

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > C48_MAX) r = C48_MAX[47:0];
        else if (v < C48_MIN) r = C48_MIN[47:0];
        else r = v[47:0];
        return r;
    endfunction

    function automatic logic in_rng(input logic signed [47:0] c, input logic [31:0] t);
        logic signed [49:0] v;
        logic signed [49:0] tw;
        v  = {{2{c[47]}}, c};
        tw = {18'd0, t};
        return (v > -tw) && (v - ONE50 < tw);
    endfunction

    function automatic logic [49:0] classify(input logic signed [47:0] c,
                                             input logic [31:0] t,
                                             input logic second);
        logic signed [49:0] v;
        logic signed [49:0] tw;
        logic signed [49:0] hi;
        logic [49:0]        r;
        v  = {{2{c[47]}}, c};
        tw = {18'd0, t};
        hi = ONE50 + tw;
        r  = {PLACE_INSIDE, c};
        if (v < -tw || v > hi) begin
            r = {PLACE_OUTSIDE, c};
        end else if (v > -tw && v < tw) begin
            r = {PLACE_BEGIN, 48'd0};
        end else if (v > ONE50 - tw && (second ? v <= hi : v < hi)) begin
            r = {PLACE_END, ONE48};
        end
        return r;
    endfunction

    // input and config registers
    logic signed [31:0] r_fx, r_fy, r_sx, r_sy, r_gx, r_gy;
    logic signed [31:0] r_a00, r_a01, r_a10, r_a11;
    logic [31:0]        r_par_tol, r_hit_tol;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fx  <= i_first_dir_x;
            r_fy  <= i_first_dir_y;
            r_sx  <= i_second_dir_x;
            r_sy  <= i_second_dir_y;
            r_gx  <= i_start_gap_x;
            r_gy  <= i_start_gap_y;
            r_a00 <= i_sys_a00;
            r_a01 <= i_sys_a01;
            r_a10 <= i_sys_a10;
            r_a11 <= i_sys_a11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_tol <= PAR_TOL_RST;
            r_hit_tol <= HIT_TOL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAR_TOL: r_par_tol <= i_cfg_data;
                CFG_HIT_TOL: r_hit_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
    end

    // pair unit: p_a*p_b +/- q_a*q_b
    logic [1:0]          r_pst;
    t_pair               r_pid;
    logic                r_psub;
    logic signed [64:0]  r_acc;
    t_pair               sel_id;
    logic signed [31:0]  p_a, p_b, q_a, q_b;
    logic                p_sub;
    logic signed [64:0]  pres;
    logic                pres_neg;
    logic [MAG_W-1:0]    pres_mag;

    logic [MAG_W-1:0]    r_n1, r_nb, r_cm, r_det_mag, r_num_mag;
    logic                r_det_neg, r_num_neg;

    assign sel_id = (r_pst == 2'd0) ? i_cmd.pair_id : r_pid;

    always_comb begin
        p_a   = r_fx;
        p_b   = r_fx;
        q_a   = r_fy;
        q_b   = r_fy;
        p_sub = 1'b0;
        unique case (sel_id)
            PR_N1:   begin p_a = r_fx;  p_b = r_fx;  q_a = r_fy;  q_b = r_fy;  end
            PR_N2:   begin p_a = r_sx;  p_b = r_sx;  q_a = r_sy;  q_b = r_sy;  end
            PR_NG:   begin p_a = r_gx;  p_b = r_gx;  q_a = r_gy;  q_b = r_gy;  end
            PR_CM1:  begin p_a = r_fx;  p_b = r_sy;  q_a = r_sx;  q_b = r_fy;  p_sub = 1'b1; end
            PR_CM2:  begin p_a = r_fx;  p_b = r_gy;  q_a = r_gx;  q_b = r_fy;  p_sub = 1'b1; end
            PR_DET:  begin p_a = r_a00; p_b = r_a11; q_a = r_a01; q_b = r_a10; p_sub = 1'b1; end
            PR_NUM0: begin p_a = r_gx;  p_b = r_a11; q_a = r_a01; q_b = r_gy;  p_sub = 1'b1; end
            PR_NUM1: begin p_a = r_a00; p_b = r_gy;  q_a = r_gx;  q_b = r_a10; p_sub = 1'b1; end
            PR_DOTG: begin p_a = r_fx;  p_b = r_gx;  q_a = r_fy;  q_b = r_gy;  end
            PR_DOTS: begin p_a = r_fx;  p_b = r_sx;  q_a = r_fy;  q_b = r_sy;  end
            default: ;
        endcase
    end

    assign pres     = r_psub ? r_acc - $signed(r_prod[64:0]) : r_acc + $signed(r_prod[64:0]);
    assign pres_neg = pres[64];
    assign pres_mag = pres_neg ? MAG_W'(-pres) : pres[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pst <= 2'd0;
        end else begin
            unique case (r_pst)
                2'd0: if (i_cmd.pair_go) r_pst <= 2'd1;
                2'd1: r_pst <= 2'd2;
                default: r_pst <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pst == 2'd0 && i_cmd.pair_go) begin
            r_pid  <= i_cmd.pair_id;
            r_psub <= p_sub;
        end
        if (r_pst == 2'd1) begin
            r_acc <= $signed(r_prod[64:0]);
        end
        if (r_pst == 2'd2) begin
            unique case (r_pid)
                PR_N1:          r_n1 <= pres[63:0];
                PR_N2, PR_NG:   r_nb <= pres[63:0];
                PR_CM1, PR_CM2: r_cm <= pres_mag;
                PR_DET: begin
                    r_det_mag <= pres_mag;
                    r_det_neg <= pres_neg;
                end
                default: begin
                    r_num_mag <= pres_mag;
                    r_num_neg <= pres_neg;
                end
            endcase
        end
    end

    // wide unit: 128 x 64 product over 32-bit chunks
    logic          r_wrun;
    logic [3:0]    r_wcnt;
    t_wide         r_wid;
    logic [127:0]  r_wx;
    logic [63:0]   r_wy;
    logic [191:0]  r_wacc;
    logic [2:0]    r_wsh;
    logic [127:0]  r_lhs;
    logic [31:0]   wx_chunk, wy_chunk;
    logic [191:0]  n_wacc;
    logic          wide_done;

    assign wx_chunk  = r_wx[{r_wcnt[2:1], 5'd0} +: 32];
    assign wy_chunk  = r_wy[{r_wcnt[0], 5'd0} +: 32];
    assign n_wacc    = r_wacc + ({128'd0, r_prod[63:0]} << {r_wsh, 5'd0});
    assign wide_done = r_wrun && (r_wcnt == 4'(WIDE_LAST));

    always_comb begin
        if (r_wrun) begin
            ma = {1'b0, wx_chunk};
            mb = {1'b0, wy_chunk};
        end else if (r_pst == 2'd0) begin
            ma = {p_a[31], p_a};
            mb = {p_b[31], p_b};
        end else begin
            ma = {q_a[31], q_a};
            mb = {q_b[31], q_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrun <= 1'b0;
            r_wcnt <= '0;
        end else if (i_cmd.wide_go) begin
            r_wrun <= 1'b1;
            r_wcnt <= '0;
        end else if (r_wrun) begin
            r_wcnt <= r_wcnt + 4'd1;
            if (wide_done) r_wrun <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wide_go) begin
            r_wid  <= i_cmd.wide_id;
            r_wacc <= '0;
            unique case (i_cmd.wide_id)
                WD_CMSQ: begin r_wx <= {64'd0, r_cm};          r_wy <= r_cm;             end
                WD_TSQ:  begin r_wx <= {96'd0, r_par_tol};     r_wy <= {32'd0, r_par_tol}; end
                WD_TN:   begin r_wx <= {64'd0, r_wacc[63:0]};  r_wy <= r_n1;             end
                default: begin r_wx <= r_wacc[127:0];          r_wy <= r_nb;             end
            endcase
        end else if (r_wrun) begin
            r_wsh <= 3'(r_wcnt[2:1]) + 3'(r_wcnt[0]);
            if (r_wcnt != 4'd0) r_wacc <= n_wacc;
            if (wide_done && r_wid == WD_CMSQ) r_lhs <= n_wacc[127:0];
        end
    end

    // divider
    logic               div_done;
    logic [QUOT_W-1:0]  div_quot;

    spi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (r_num_mag),
        .i_divisor  (i_cmd.div_by_det ? r_det_mag : r_n1),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // held coordinates
    logic signed [47:0] r_held0, r_held1;
    logic signed [63:0] r_q0;
    logic               q_neg;
    logic signed [63:0] qs;
    logic signed [63:0] c1_sum;
    logic signed [47:0] col_a, col_b;

    assign q_neg  = (i_cmd.coord_op == CO_U0 || i_cmd.coord_op == CO_U1)
                    ? (r_num_neg ^ r_det_neg) : r_num_neg;
    assign qs     = q_neg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    assign c1_sum = r_q0 + qs;
    assign col_a  = sat48(r_q0);
    assign col_b  = sat48(c1_sum);

    logic [49:0] cls0, cls1;
    assign cls0 = classify(r_held0, r_hit_tol, 1'b0);
    assign cls1 = classify(r_held1, r_hit_tol, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0 <= '0;
            r_held1 <= '0;
        end else if (i_cmd.emit) begin
            r_held0 <= cls0[47:0];
            r_held1 <= cls1[47:0];
        end else if (div_done) begin
            unique case (i_cmd.coord_op)
                CO_U0: r_held0 <= sat48(qs);
                CO_U1: r_held1 <= sat48(qs);
                CO_Q0: r_q0    <= qs;
                CO_COL: begin
                    if (col_b < col_a) begin
                        r_held0 <= col_b;
                        r_held1 <= col_a;
                    end else begin
                        r_held0 <= col_a;
                        r_held1 <= col_b;
                    end
                end
            endcase
        end
    end

    // output register
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_hit_kind     <= i_cmd.kind;
            o_first_place  <= cls0[49:48];
            o_second_place <= cls1[49:48];
            o_first_coord  <= cls0[47:0];
            o_second_coord <= cls1[47:0];
        end
    end

    assign o_out_valid = r_ovalid;

    // status
    logic [191:0] lhs_w;
    logic signed [49:0] h0w, h1w, tw;

    assign lhs_w = {r_lhs, 64'd0};
    assign h0w   = {{2{r_held0[47]}}, r_held0};
    assign h1w   = {{2{r_held1[47]}}, r_held1};
    assign tw    = {18'd0, r_hit_tol};

    assign o_stat.pair_done = (r_pst == 2'd2);
    assign o_stat.wide_done = wide_done;
    assign o_stat.div_done  = div_done;
    assign o_stat.n1_zero   = (r_n1 == '0);
    assign o_stat.det_zero  = (r_det_mag == '0);
    assign o_stat.tilt_ge   = (lhs_w >= r_wacc);
    assign o_stat.tilt_le   = (lhs_w <= r_wacc);
    assign o_stat.rng0      = in_rng(r_held0, r_hit_tol);
    assign o_stat.rng1      = in_rng(r_held1, r_hit_tol);
    assign o_stat.span      = (h0w < tw) && (h1w - ONE50 > -tw);
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

endmodule

`default_nettype wire

/* hdl/spi_ctrl.sv */
// controller state machine: sequences products, tilt tests, divisions and the result
// drives t_cmd and reads t_stat; uses spi_pkg and the assertion macro header
`default_nettype none

`include "segment_pair_intersection_assert.svh"

module spi_ctrl import spi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_N1, S_N2, S_N1CHK, S_CM1,
        S_TCM, S_TTS, S_TTN, S_TFULL, S_TCHK,
        S_DET, S_DETCHK, S_NUM0, S_DIV0, S_NUM1, S_DIV1, S_JNP,
        S_NG, S_CM2, S_DOTG, S_DIVG, S_DOTS, S_DIVS, S_JCOL,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state op_next;
    logic   r_wait;
    logic   r_col;
    t_kind  r_kind;
    logic   is_op;
    logic   op_done;

    always_comb begin
        o_cmd   = '0;
        is_op   = 1'b1;
        op_done = i_stat.pair_done;
        op_next = S_IDLE;
        unique case (r_state)
            S_N1:   begin o_cmd.pair_id = PR_N1;   op_next = S_N2;    end
            S_N2:   begin o_cmd.pair_id = PR_N2;   op_next = S_N1CHK; end
            S_CM1:  begin o_cmd.pair_id = PR_CM1;  op_next = S_TCM;   end
            S_DET:  begin o_cmd.pair_id = PR_DET;  op_next = S_DETCHK; end
            S_NUM0: begin o_cmd.pair_id = PR_NUM0; op_next = S_DIV0;  end
            S_NUM1: begin o_cmd.pair_id = PR_NUM1; op_next = S_DIV1;  end
            S_NG:   begin o_cmd.pair_id = PR_NG;   op_next = S_CM2;   end
            S_CM2:  begin o_cmd.pair_id = PR_CM2;  op_next = S_TCM;   end
            S_DOTG: begin o_cmd.pair_id = PR_DOTG; op_next = S_DIVG;  end
            S_DOTS: begin o_cmd.pair_id = PR_DOTS; op_next = S_DIVS;  end
            S_TCM:   begin o_cmd.wide_id = WD_CMSQ; op_next = S_TTS;   end
            S_TTS:   begin o_cmd.wide_id = WD_TSQ;  op_next = S_TTN;   end
            S_TTN:   begin o_cmd.wide_id = WD_TN;   op_next = S_TFULL; end
            S_TFULL: begin o_cmd.wide_id = WD_FULL; op_next = S_TCHK;  end
            S_DIV0: begin
                o_cmd.div_by_det = 1'b1;
                o_cmd.coord_op   = CO_U0;
                op_next          = S_NUM1;
            end
            S_DIV1: begin
                o_cmd.div_by_det = 1'b1;
                o_cmd.coord_op   = CO_U1;
                op_next          = S_JNP;
            end
            S_DIVG: begin o_cmd.coord_op = CO_Q0;  op_next = S_DOTS; end
            S_DIVS: begin o_cmd.coord_op = CO_COL; op_next = S_JCOL; end
            default: is_op = 1'b0;
        endcase

        unique case (r_state)
            S_TCM, S_TTS, S_TTN, S_TFULL: begin
                o_cmd.wide_go = !r_wait;
                op_done       = i_stat.wide_done;
            end
            S_DIV0, S_DIV1, S_DIVG, S_DIVS: begin
                o_cmd.div_go = !r_wait;
                op_done      = i_stat.div_done;
            end
            S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.kind = r_kind;
            end
            default: o_cmd.pair_go = is_op && !r_wait;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_col   <= 1'b0;
            r_kind  <= KIND_NONE;
        end else if (is_op) begin
            if (!r_wait) begin
                r_wait <= 1'b1;
            end else if (op_done) begin
                r_wait  <= 1'b0;
                r_state <= op_next;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_col   <= 1'b0;
                        r_state <= S_N1;
                    end
                end
                S_N1CHK: begin
                    if (i_stat.n1_zero) begin
                        r_kind  <= KIND_NONE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_CM1;
                    end
                end
                S_TCHK: begin
                    if (!r_col) begin
                        if (i_stat.tilt_ge) begin
                            r_state <= S_DET;
                        end else begin
                            r_col   <= 1'b1;
                            r_state <= S_NG;
                        end
                    end else if (i_stat.tilt_le) begin
                        r_state <= S_DOTG;
                    end else begin
                        r_kind  <= KIND_NONE;
                        r_state <= S_EMIT;
                    end
                end
                S_DETCHK: begin
                    if (i_stat.det_zero) begin
                        r_kind  <= KIND_NONE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_NUM0;
                    end
                end
                S_JNP: begin
                    if (!i_stat.rng1) r_kind <= KIND_NONE;
                    else if (i_stat.rng0) r_kind <= KIND_SEG;
                    else r_kind <= KIND_LINE;
                    r_state <= S_EMIT;
                end
                S_JCOL: begin
                    r_kind  <= (i_stat.rng0 || i_stat.rng1 || i_stat.span)
                               ? KIND_PAR_SEG : KIND_PAR_LINE;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SPI_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({o_cmd.pair_go, o_cmd.wide_go, o_cmd.div_go, o_cmd.emit}))
    `SPI_ASSERT_IMP(a_div_nonzero, o_cmd.div_go, (o_cmd.div_by_det ? !i_stat.det_zero : !i_stat.n1_zero))
    `SPI_ASSERT_NXT(a_emit_idle, o_cmd.emit, (r_state == S_IDLE))

endmodule

`default_nettype wire

/* hdl/segment_pair_intersection.sv */
// top level: joins spi_ctrl and spi_dp; uses spi_pkg
// time from input transfer to result valid depends on the path: a zero first tangent, a
// singular matrix, parallel edges off the line, a crossing, or collinear edges
// one item at a time: next input taken the cycle after the result loads, even while it waits
// pace set by the serial divider and the shared 33x33 multiplier
// synchronous active-low reset: tolerances to defaults, held coordinates to zero, no result
`default_nettype none

module segment_pair_intersection import spi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_first_dir_x,
    input  logic signed [31:0]    i_first_dir_y,
    input  logic signed [31:0]    i_second_dir_x,
    input  logic signed [31:0]    i_second_dir_y,
    input  logic signed [31:0]    i_start_gap_x,
    input  logic signed [31:0]    i_start_gap_y,
    input  logic signed [31:0]    i_sys_a00,
    input  logic signed [31:0]    i_sys_a01,
    input  logic signed [31:0]    i_sys_a10,
    input  logic signed [31:0]    i_sys_a11,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_hit_kind,
    output logic [1:0]            o_first_place,
    output logic [1:0]            o_second_place,
    output logic signed [47:0]    o_first_coord,
    output logic signed [47:0]    o_second_coord,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    spi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spi_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (i_in_valid && o_in_ready),
        .i_first_dir_x  (i_first_dir_x),
        .i_first_dir_y  (i_first_dir_y),
        .i_second_dir_x (i_second_dir_x),
        .i_second_dir_y (i_second_dir_y),
        .i_start_gap_x  (i_start_gap_x),
        .i_start_gap_y  (i_start_gap_y),
        .i_sys_a00      (i_sys_a00),
        .i_sys_a01      (i_sys_a01),
        .i_sys_a10      (i_sys_a10),
        .i_sys_a11      (i_sys_a11),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit_kind     (o_hit_kind),
        .o_first_place  (o_first_place),
        .o_second_place (o_second_place),
        .o_first_coord  (o_first_coord),
        .o_second_coord (o_second_coord)
    );

endmodule

`default_nettype wire
